@@ rtl/complex_arithmetic_unit_top_defines.svh @@
// Assertion macros for the complex arithmetic unit.
`ifndef COMPLEX_ARITHMETIC_UNIT_TOP_DEFINES_SVH
`define COMPLEX_ARITHMETIC_UNIT_TOP_DEFINES_SVH

// Same-cycle implication, disabled in reset.
`define CAU_IMPLIES(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication, disabled in reset.
`define CAU_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

@@ rtl/cau_pkg.sv @@
// Shared types and constants of the complex arithmetic unit.
package cau_pkg;

    localparam int FRAC_BITS_DEF = 8;
    localparam int QBITS = 17;

    typedef enum logic [2:0] {
        ACT_EQ  = 3'd0,
        ACT_ADD = 3'd1,
        ACT_SUB = 3'd2,
        ACT_MUL = 3'd3,
        ACT_DIV = 3'd4
    } action_t;

    typedef enum logic [1:0] {
        ST_OK  = 2'd0,
        ST_SAT = 2'd1,
        ST_DZ  = 2'd2
    } status_t;

endpackage

@@ rtl/complex_arithmetic_unit_top.sv @@
// Complex arithmetic unit: pipelined add, subtract, multiply, divide, compare.
// Pipeline from input beat to output register: products, operand select,
// rounded dividend, 17 restoring divider stages, sign and saturation.
// Throughput: one beat per cycle; the whole pipeline stalls on output backpressure.
// Reset: synchronous active-low aresetn clears the stage valid bits only.
`include "complex_arithmetic_unit_top_defines.svh"
module complex_arithmetic_unit_top #(
    parameter int FRAC_BITS = cau_pkg::FRAC_BITS_DEF
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic [2:0]         s_action,
    input  logic signed [15:0] s_first_real,
    input  logic signed [15:0] s_first_imag,
    input  logic signed [15:0] s_second_real,
    input  logic signed [15:0] s_second_imag,
    output logic               m_valid,
    input  logic               m_ready,
    output logic signed [15:0] m_result_real,
    output logic signed [15:0] m_result_imag,
    output logic               m_equal_flag,
    output logic [1:0]         m_status
);

    localparam int QB = cau_pkg::QBITS;
    localparam int MW = 33;
    localparam int W  = MW + FRAC_BITS + 1;
    localparam int CW = (W > 32 + QB ? W : 32 + QB) + 1;

    logic en;
    assign en = !m_valid || m_ready;
    assign s_ready = en;

    // stage 1: products
    logic                v1_reg;
    logic [2:0]          act1_reg;
    logic                eq1_reg;
    logic signed [15:0]  a1_reg, b1_reg, c1_reg, d1_reg;
    logic signed [31:0]  pac_reg, pbd_reg, pad_reg, pbc_reg, pcc_reg, pdd_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
        end else if (en) begin
            v1_reg <= s_valid;
        end
        if (en) begin
            act1_reg <= s_action;
            eq1_reg  <= (s_first_real == s_second_real) && (s_first_imag == s_second_imag);
            a1_reg   <= s_first_real;
            b1_reg   <= s_first_imag;
            c1_reg   <= s_second_real;
            d1_reg   <= s_second_imag;
            pac_reg  <= 32'(s_first_real) * 32'(s_second_real);
            pbd_reg  <= 32'(s_first_imag) * 32'(s_second_imag);
            pad_reg  <= 32'(s_first_real) * 32'(s_second_imag);
            pbc_reg  <= 32'(s_first_imag) * 32'(s_second_real);
            pcc_reg  <= 32'(s_second_real) * 32'(s_second_real);
            pdd_reg  <= 32'(s_second_imag) * 32'(s_second_imag);
        end
    end

    // stage 2: numerators and denominator per action
    logic signed [33:0] nre_next, nim_next;
    logic [31:0]        den_next;
    logic               up_next, dz_next;
    logic [31:0]        dsum;

    assign dsum = 32'(pcc_reg) + 32'(pdd_reg);

    always_comb begin
        nre_next = '0;
        nim_next = '0;
        den_next = 32'd1;
        up_next  = 1'b0;
        dz_next  = 1'b0;
        unique case (cau_pkg::action_t'(act1_reg))
            cau_pkg::ACT_ADD: begin
                nre_next = 34'(a1_reg) + 34'(c1_reg);
                nim_next = 34'(b1_reg) + 34'(d1_reg);
            end
            cau_pkg::ACT_SUB: begin
                nre_next = 34'(a1_reg) - 34'(c1_reg);
                nim_next = 34'(b1_reg) - 34'(d1_reg);
            end
            cau_pkg::ACT_MUL: begin
                nre_next = 34'(pac_reg) - 34'(pbd_reg);
                nim_next = 34'(pad_reg) + 34'(pbc_reg);
                den_next = 32'd1 << FRAC_BITS;
            end
            cau_pkg::ACT_DIV: begin
                if (dsum == 32'd0) begin
                    dz_next = 1'b1;
                end else begin
                    nre_next = 34'(pac_reg) + 34'(pbd_reg);
                    nim_next = 34'(pbc_reg) - 34'(pad_reg);
                    den_next = dsum;
                    up_next  = 1'b1;
                end
            end
            default: begin
                den_next = 32'd1;
            end
        endcase
    end

    logic          v2_reg, eq2_reg, up2_reg, dz2_reg, nre2_reg, nim2_reg;
    logic [MW-1:0] mre2_reg, mim2_reg;
    logic [31:0]   den2_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v2_reg <= 1'b0;
        end else if (en) begin
            v2_reg <= v1_reg;
        end
        if (en) begin
            eq2_reg  <= eq1_reg;
            up2_reg  <= up_next;
            dz2_reg  <= dz_next;
            den2_reg <= den_next;
            nre2_reg <= nre_next[33];
            nim2_reg <= nim_next[33];
            mre2_reg <= nre_next[33] ? MW'(-nre_next) : MW'(nre_next);
            mim2_reg <= nim_next[33] ? MW'(-nim_next) : MW'(nim_next);
        end
    end

    // stage 3 and divider stages
    logic          vd_reg   [0:QB];
    logic          eqd_reg  [0:QB];
    logic          dzd_reg  [0:QB];
    logic          nre_reg  [0:QB];
    logic          nim_reg  [0:QB];
    logic          ore_reg  [0:QB];
    logic          oim_reg  [0:QB];
    logic [31:0]   den_reg  [0:QB-1];
    logic [W-1:0]  rre_reg  [0:QB-1];
    logic [W-1:0]  rim_reg  [0:QB-1];
    logic [QB-1:0] qre_reg  [0:QB];
    logic [QB-1:0] qim_reg  [0:QB];

    logic [W-1:0]  dre_next, dim_next;
    logic [CW-1:0] dlim;

    always_comb begin
        dre_next = (W'(mre2_reg) << (up2_reg ? FRAC_BITS : 0)) + W'(den2_reg >> 1);
        dim_next = (W'(mim2_reg) << (up2_reg ? FRAC_BITS : 0)) + W'(den2_reg >> 1);
        dlim     = CW'(den2_reg) << QB;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int k = 0; k <= QB; k++) begin
                vd_reg[k] <= 1'b0;
            end
        end else if (en) begin
            vd_reg[0] <= v2_reg;
            for (int k = 0; k < QB; k++) begin
                vd_reg[k+1] <= vd_reg[k];
            end
        end
        if (en) begin
            eqd_reg[0] <= eq2_reg;
            dzd_reg[0] <= dz2_reg;
            nre_reg[0] <= nre2_reg;
            nim_reg[0] <= nim2_reg;
            den_reg[0] <= den2_reg;
            rre_reg[0] <= dre_next;
            rim_reg[0] <= dim_next;
            ore_reg[0] <= CW'(dre_next) >= dlim;
            oim_reg[0] <= CW'(dim_next) >= dlim;
            qre_reg[0] <= '0;
            qim_reg[0] <= '0;
        end
    end

    for (genvar k = 0; k < QB; k++) begin : g_div
        localparam int SH = QB - 1 - k;
        logic [CW-1:0] dsh;
        logic          tre, tim;
        assign dsh = CW'(den_reg[k]) << SH;
        assign tre = CW'(rre_reg[k]) >= dsh;
        assign tim = CW'(rim_reg[k]) >= dsh;
        always_ff @(posedge aclk) begin
            if (en) begin
                eqd_reg[k+1] <= eqd_reg[k];
                dzd_reg[k+1] <= dzd_reg[k];
                nre_reg[k+1] <= nre_reg[k];
                nim_reg[k+1] <= nim_reg[k];
                ore_reg[k+1] <= ore_reg[k];
                oim_reg[k+1] <= oim_reg[k];
                qre_reg[k+1] <= qre_reg[k] | (QB'(tre) << SH);
                qim_reg[k+1] <= qim_reg[k] | (QB'(tim) << SH);
            end
        end
        if (k < QB - 1) begin : g_rem
            always_ff @(posedge aclk) begin
                if (en) begin
                    den_reg[k+1] <= den_reg[k];
                    rre_reg[k+1] <= tre ? W'(CW'(rre_reg[k]) - dsh) : rre_reg[k];
                    rim_reg[k+1] <= tim ? W'(CW'(rim_reg[k]) - dsh) : rim_reg[k];
                end
            end
        end
    end

    // final stage: sign, saturate, status
    function automatic logic [16:0] cau_sat(input logic neg, input logic ovf,
                                            input logic [QB-1:0] q);
        logic [QB:0] v;
        v = neg ? -(QB+1)'(q) : (QB+1)'(q);
        if (!neg && (ovf || q > QB'(32767))) begin
            return {1'b1, 16'sh7fff};
        end else if (neg && (ovf || q > QB'(32768))) begin
            return {1'b1, 16'sh8000};
        end
        return {1'b0, v[15:0]};
    endfunction

    logic [16:0] sre, sim;
    assign sre = cau_sat(nre_reg[QB], ore_reg[QB], qre_reg[QB]);
    assign sim = cau_sat(nim_reg[QB], oim_reg[QB], qim_reg[QB]);

    logic        m_valid_reg, m_eq_reg;
    logic [15:0] m_re_reg, m_im_reg;
    logic [1:0]  m_st_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (en) begin
            m_valid_reg <= vd_reg[QB];
        end
        if (en) begin
            m_re_reg <= sre[15:0];
            m_im_reg <= sim[15:0];
            m_eq_reg <= eqd_reg[QB];
            if (dzd_reg[QB]) begin
                m_st_reg <= cau_pkg::ST_DZ;
            end else if (sre[16] || sim[16]) begin
                m_st_reg <= cau_pkg::ST_SAT;
            end else begin
                m_st_reg <= cau_pkg::ST_OK;
            end
        end
    end

    assign m_valid       = m_valid_reg;
    assign m_result_real = m_re_reg;
    assign m_result_imag = m_im_reg;
    assign m_equal_flag  = m_eq_reg;
    assign m_status      = m_st_reg;

    logic out_zero, out_rail;
    assign out_zero = m_result_real == 16'sd0 && m_result_imag == 16'sd0;
    assign out_rail = m_result_real == 16'sh7fff || m_result_real == 16'sh8000 ||
                      m_result_imag == 16'sh7fff || m_result_imag == 16'sh8000;

    `CAU_IMPLIES(a_dz_zero, aclk, aresetn, m_valid && m_status == cau_pkg::ST_DZ, out_zero)
    `CAU_IMPLIES(a_sat_rail, aclk, aresetn, m_valid && m_status == cau_pkg::ST_SAT, out_rail)
    `CAU_NEXT(a_last_to_out, aclk, aresetn, en && vd_reg[QB], m_valid)

endmodule
